>>> hdl/lslp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the link status LED pattern block.
// No dependencies; every other file imports this package.
package lslp_pkg;

    localparam int SESSION_COUNT_WIDTH = 8;
    localparam logic [SESSION_COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [7:0] CONNECTED_GREEN = 8'd255;

    // Divider operand widths
    localparam int DVD_W = 32;
    localparam int DVS_W = 16;
    localparam int STEP_W = $clog2(DVD_W);

    typedef enum logic [1:0] {
        OP_RENDER         = 2'd0,
        OP_SESSION_START  = 2'd1,
        OP_SESSION_END    = 2'd2,
        OP_SET_CONNECTING = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        LINK_DISCONNECTED = 2'd0,
        LINK_CONNECTING   = 2'd1,
        LINK_CONNECTED    = 2'd2
    } link_t;

    typedef enum logic [2:0] {
        REG_DISC_PERIOD = 3'd0,
        REG_DISC_ON     = 3'd1,
        REG_DISC_RED    = 3'd2,
        REG_CONN_PERIOD = 3'd3,
        REG_CONN_RMIN   = 3'd4,
        REG_CONN_RMAX   = 3'd5,
        REG_CONN_GMIN   = 3'd6,
        REG_CONN_GMAX   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] disc_period;
        logic [15:0] disc_on;
        logic [7:0]  disc_red;
        logic [15:0] conn_period;
        logic [7:0]  conn_red_min;
        logic [7:0]  conn_red_max;
        logic [7:0]  conn_green_min;
        logic [7:0]  conn_green_max;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

>>> hdl/lslp_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register bank for the LED pattern block.
// Depends on lslp_pkg for the register index codes and the cfg_t struct.
module lslp_cfg_regs
    import lslp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.disc_period    <= 16'd1000;
            cfg_reg.disc_on        <= 16'd100;
            cfg_reg.disc_red       <= 8'd64;
            cfg_reg.conn_period    <= 16'd2000;
            cfg_reg.conn_red_min   <= 8'd0;
            cfg_reg.conn_red_max   <= 8'd64;
            cfg_reg.conn_green_min <= 8'd0;
            cfg_reg.conn_green_max <= 8'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DISC_PERIOD: cfg_reg.disc_period    <= cfg_wdata;
                REG_DISC_ON:     cfg_reg.disc_on        <= cfg_wdata;
                REG_DISC_RED:    cfg_reg.disc_red       <= cfg_wdata[7:0];
                REG_CONN_PERIOD: cfg_reg.conn_period    <= cfg_wdata;
                REG_CONN_RMIN:   cfg_reg.conn_red_min   <= cfg_wdata[7:0];
                REG_CONN_RMAX:   cfg_reg.conn_red_max   <= cfg_wdata[7:0];
                REG_CONN_GMIN:   cfg_reg.conn_green_min <= cfg_wdata[7:0];
                REG_CONN_GMAX:   cfg_reg.conn_green_max <= cfg_wdata[7:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/lslp_div.sv
`timescale 1ns / 1ps
// Shared restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
// Depends on lslp_pkg for the request and response structs.
module lslp_div
    import lslp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   shifted;
    logic             ge;
    logic [DVS_W:0]   diff;

    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so the top bit drops
            rem_reg <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> hdl/link_status_led_pattern.sv
`timescale 1ns / 1ps
// Top level of the link status LED pattern block: event decode, sequencer, output register.
// Depends on lslp_pkg, lslp_cfg_regs and lslp_div.
//
// Channel   | Direction | Handshake                    | Contents
// s_axis    | in        | s_axis_tvalid / s_axis_tready | opcode, connecting flag, elapsed ms
// m_axis    | out       | m_axis_tvalid / m_axis_tready | red, green, link state
// cfg       | in        | cfg_we, no wait              | register index and write data
//
// Connected items need no divider run; disconnected items use at most one and connecting items up to
// three runs of the shared divider (phase, red ramp, green ramp).
// One item is in work at a time; s_axis_tready is low while the sequencer runs.
// A finished result waits in the output register while the next item is taken.
// Reset clears the session count, the connecting flag and the registers to defaults.
module link_status_led_pattern
    import lslp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [0] connecting_value, [32:1] elapsed_time, zero pad
    input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [7:0] red, [15:8] green, [17:16] link_state, zero pad
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_MOD_GO   = 10'b00_0000_0010,
        ST_MOD_WAIT = 10'b00_0000_0100,
        ST_PHASE    = 10'b00_0000_1000,
        ST_RED_MUL  = 10'b00_0001_0000,
        ST_RED_GO   = 10'b00_0010_0000,
        ST_RED_WAIT = 10'b00_0100_0000,
        ST_GRN_MUL  = 10'b00_1000_0000,
        ST_GRN_GO   = 10'b01_0000_0000,
        ST_GRN_WAIT = 10'b10_0000_0000
    } state_t;

    // Note: a finishing state folds into each path's last step via done_reg below.

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t   state_reg, state_next;
    logic [SESSION_COUNT_WIDTH-1:0] count_reg, count_next;
    logic     flag_reg, flag_next;
    link_t    link_reg, link_next;
    logic [31:0] elapsed_reg;
    logic [15:0] phase_reg;
    logic [31:0] prod_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic        done_reg;

    logic        out_valid_reg;
    logic [7:0]  out_red_reg;
    logic [7:0]  out_green_reg;
    link_t       out_link_reg;

    op_t         op;
    logic        in_accept;
    logic        out_free;
    logic [15:0] period;
    logic [14:0] half;
    logic [8:0]  diff_r, diff_g;
    logic [31:0] span;
    logic [47:0] mul_full;

    lslp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lslp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign op            = op_t'(s_axis_tuser);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !done_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Apply the event before the link state is chosen
    always_comb
    begin
        count_next = count_reg;
        flag_next  = flag_reg;
        case (op)
            OP_SESSION_START:
            begin
                if (count_reg != COUNT_MAX)
                    count_next = count_reg + 1'b1;
            end
            OP_SESSION_END:
            begin
                if (count_reg != '0)
                    count_next = count_reg - 1'b1;
            end
            OP_SET_CONNECTING: flag_next = s_axis_tdata[0];
            default:           count_next = count_reg;
        endcase
        if (count_next != '0)
            link_next = LINK_CONNECTED;
        else if (flag_next)
            link_next = LINK_CONNECTING;
        else
            link_next = LINK_DISCONNECTED;
    end

    assign period = (link_reg == LINK_CONNECTING) ? cfg.conn_period : cfg.disc_period;
    assign half   = cfg.conn_period[15:1];

    // Colour span taken modulo 2^32: sign-extend the 9-bit difference
    assign diff_r   = {1'b0, cfg.conn_red_max} - {1'b0, cfg.conn_red_min};
    assign diff_g   = {1'b0, cfg.conn_green_max} - {1'b0, cfg.conn_green_min};
    assign span     = (state_reg == ST_GRN_MUL) ? {{23{diff_g[8]}}, diff_g}
                                                : {{23{diff_r[8]}}, diff_r};
    assign mul_full = {16'd0, span} * {32'd0, phase_reg};

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = {1'b0, half};
        case (state_reg)
            ST_MOD_GO:
            begin
                div_req.start    = (period != 16'd0);
                div_req.dividend = elapsed_reg;
                div_req.divisor  = period;
            end
            ST_RED_GO, ST_GRN_GO: div_req.start = 1'b1;
            default:              div_req.start = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && link_next != LINK_CONNECTED)
                    state_next = ST_MOD_GO;
            end
            ST_MOD_GO:   state_next = (period == 16'd0) ? ST_PHASE : ST_MOD_WAIT;
            ST_MOD_WAIT: state_next = div_rsp.done ? ST_PHASE : ST_MOD_WAIT;
            ST_PHASE:    state_next = (link_reg == LINK_CONNECTING) ? ST_RED_MUL : ST_IDLE;
            ST_RED_MUL:  state_next = (half == 15'd0) ? ST_GRN_MUL : ST_RED_GO;
            ST_RED_GO:   state_next = ST_RED_WAIT;
            ST_RED_WAIT: state_next = div_rsp.done ? ST_GRN_MUL : ST_RED_WAIT;
            ST_GRN_MUL:  state_next = (half == 15'd0) ? ST_IDLE : ST_GRN_GO;
            ST_GRN_GO:   state_next = ST_GRN_WAIT;
            ST_GRN_WAIT: state_next = div_rsp.done ? ST_IDLE : ST_GRN_WAIT;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            link_reg      <= LINK_DISCONNECTED;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                count_reg <= count_next;
                flag_reg  <= flag_next;
                link_reg  <= link_next;
            end

            // done_reg marks a finished colour waiting for the output register
            if (in_accept && link_next == LINK_CONNECTED)
                done_reg <= 1'b1;
            else if (state_reg == ST_PHASE && link_reg != LINK_CONNECTING)
                done_reg <= 1'b1;
            else if (state_reg == ST_GRN_MUL && half == 15'd0)
                done_reg <= 1'b1;
            else if (state_reg == ST_GRN_WAIT && div_rsp.done)
                done_reg <= 1'b1;
            else if (done_reg && out_free)
                done_reg <= 1'b0;

            if (done_reg && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            elapsed_reg <= s_axis_tdata[32:1];
            red_reg     <= 8'd0;
            green_reg   <= (link_next == LINK_CONNECTED) ? CONNECTED_GREEN : 8'd0;
        end

        case (state_reg)
            ST_MOD_GO:
            begin
                if (period == 16'd0)
                    phase_reg <= 16'd0;
            end
            ST_MOD_WAIT:
            begin
                if (div_rsp.done)
                    phase_reg <= div_rsp.remainder;
            end
            ST_PHASE:
            begin
                if (link_reg == LINK_CONNECTING)
                begin
                    // fold the second half of the ramp back down
                    if (phase_reg > {1'b0, half})
                        phase_reg <= cfg.conn_period - phase_reg;
                end
                else if (phase_reg < cfg.disc_on)
                begin
                    red_reg <= cfg.disc_red;
                end
            end
            ST_RED_MUL:
            begin
                prod_reg <= mul_full[31:0];
                red_reg  <= cfg.conn_red_min;
            end
            ST_RED_WAIT:
            begin
                if (div_rsp.done)
                    red_reg <= cfg.conn_red_min + div_rsp.quotient[7:0];
            end
            ST_GRN_MUL:
            begin
                prod_reg  <= mul_full[31:0];
                green_reg <= cfg.conn_green_min;
            end
            ST_GRN_WAIT:
            begin
                if (div_rsp.done)
                    green_reg <= cfg.conn_green_min + div_rsp.quotient[7:0];
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase

        if (done_reg && out_free)
        begin
            out_red_reg   <= red_reg;
            out_green_reg <= green_reg;
            out_link_reg  <= link_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_link_reg, out_green_reg, out_red_reg};

`ifndef NO_ASSERTIONS
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_MOD_WAIT || state_reg == ST_RED_WAIT
                          || state_reg == ST_GRN_WAIT))
        else $error("divider finished outside a wait state");

    a_connected_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && count_next != '0) |=> (state_reg == ST_IDLE && done_reg))
        else $error("connected item did not finish at once");

    a_connected_colour: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_link_reg == LINK_CONNECTED)
            |-> (out_red_reg == 8'd0 && out_green_reg == CONNECTED_GREEN))
        else $error("connected colour wrong");

    a_disc_no_green: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_link_reg == LINK_DISCONNECTED) |-> out_green_reg == 8'd0)
        else $error("green lit while disconnected");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input taken while sequencer busy");
`endif

endmodule
